### hdl/u2u_pkg.sv
// u2u_pkg: shared types and constants for the utf-8 to ucs-2 decoder
// no dependencies
`default_nettype none

package u2u_pkg;

	localparam int unsigned LenW  = 3;
	localparam int unsigned CodeW = 16;

	localparam logic [LenW-1:0] LEN_NONE = 3'd0;
	localparam logic [LenW-1:0] LEN_ONE  = 3'd1;
	localparam logic [LenW-1:0] LEN_TWO  = 3'd2;
	localparam logic [LenW-1:0] LEN_THR  = 3'd3;
	localparam logic [LenW-1:0] LEN_FOUR = 3'd4;
	localparam logic [LenW-1:0] LEN_FIVE = 3'd5;
	localparam logic [LenW-1:0] LEN_SIX  = 3'd6;

	localparam logic [7:0] BYTE_NUL = 8'h00;

	typedef struct packed {
		logic [LenW-1:0]  remaining;
		logic [CodeW-1:0] partial;
		logic [LenW-1:0]  cur_len;
	} dec_state_t;

	typedef struct packed {
		logic [CodeW-1:0] code_unit;
		logic [LenW-1:0]  seq_length;
		logic             end_of_string;
		logic             bad_lead;
	} dec_result_t;

	typedef struct packed {
		logic [LenW-1:0]  len;
		logic [CodeW-1:0] payload;
		logic             bad;
	} lead_info_t;

endpackage

`default_nettype wire

### hdl/u2u_lead_dec.sv
// u2u_lead_dec: classifies a lead byte into sequence length and payload bits
// depends on u2u_pkg
`default_nettype none

module u2u_lead_dec
	import u2u_pkg::*;
(
	input  wire logic [7:0] data,
	output lead_info_t      info
);

	always_comb begin
		info = '{len: LEN_NONE, payload: '0, bad: 1'b0};
		if (!data[7]) begin
			info.len     = LEN_ONE;
			info.payload = {8'd0, data};
		end else if (!data[5]) begin
			info.len     = LEN_TWO;
			info.payload = {11'd0, data[4:0]};
		end else if (!data[4]) begin
			info.len     = LEN_THR;
			info.payload = {12'd0, data[3:0]};
		end else if (!data[3]) begin
			info.len     = LEN_FOUR;
			info.payload = {13'd0, data[2:0]};
		end else if (!data[2]) begin
			info.len     = LEN_FIVE;
			info.payload = {14'd0, data[1:0]};
		end else if (!data[1]) begin
			info.len     = LEN_SIX;
			info.payload = {15'd0, data[0]};
		end else begin
			info.bad = 1'b1;
		end
	end

endmodule

`default_nettype wire

### hdl/u2u_step.sv
// u2u_step: next-state and result logic for one byte of the stream
// depends on u2u_pkg and u2u_lead_dec
`default_nettype none

module u2u_step
	import u2u_pkg::*;
(
	input  wire logic [7:0] data,
	input  wire dec_state_t cur,
	output dec_state_t      nxt,
	output logic            emit,
	output dec_result_t     res
);

	lead_info_t lead;

	u2u_lead_dec u_lead (
		.data (data),
		.info (lead)
	);

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '{code_unit: '0, seq_length: LEN_NONE, end_of_string: 1'b0, bad_lead: 1'b0};
		if (cur.remaining != LEN_NONE) begin
			// shift in six payload bits, keep low 16
			nxt.partial   = {cur.partial[CodeW-7:0], data[5:0]};
			nxt.remaining = cur.remaining - 3'd1;
			if (cur.remaining == LEN_ONE) begin
				emit           = 1'b1;
				res.code_unit  = {cur.partial[CodeW-7:0], data[5:0]};
				res.seq_length = cur.cur_len;
				nxt.partial    = '0;
				nxt.cur_len    = LEN_NONE;
			end
		end else if (data == BYTE_NUL) begin
			emit              = 1'b1;
			res.end_of_string = 1'b1;
		end else if (lead.bad) begin
			emit         = 1'b1;
			res.bad_lead = 1'b1;
		end else if (lead.len == LEN_ONE) begin
			emit           = 1'b1;
			res.code_unit  = lead.payload;
			res.seq_length = LEN_ONE;
		end else begin
			nxt.partial   = lead.payload;
			nxt.cur_len   = lead.len;
			nxt.remaining = lead.len - 3'd1;
		end
	end

endmodule

`default_nettype wire

### hdl/utf8_to_ucs2_decoder.sv
// utf8_to_ucs2_decoder: top level, one utf-8 byte in, one ucs-2 result per sequence
// depends on u2u_pkg and u2u_step
// path: the last byte of a sequence passes the input register, then its result is held in the result register
// throughput: one byte per cycle while out_ready takes results; input register and
// result register let a new byte enter while a result waits on out_ready, unless the held byte would emit a result too
// reset: asynchronous, clears valids and decode state to a sequence boundary
`default_nettype none

module utf8_to_ucs2_decoder
	import u2u_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      code_unit,
	output logic [2:0]       seq_length,
	output logic             end_of_string,
	output logic             bad_lead
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	logic        emit;
	dec_result_t res;
	dec_result_t res_q;
	logic        out_free;
	logic        advance;

	u2u_step u_step (
		.data (byte_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res)
	);

	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{remaining: LEN_NONE, partial: '0, cur_len: LEN_NONE};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign code_unit     = res_q.code_unit;
	assign seq_length    = res_q.seq_length;
	assign end_of_string = res_q.end_of_string;
	assign bad_lead      = res_q.bad_lead;

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.remaining != LEN_NONE |-> state_q.remaining < state_q.cur_len)
		else $error("remaining count not below sequence length");

	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q.remaining != LEN_NONE |=>
		state_q.remaining == $past(state_q.remaining) - 3'd1)
		else $error("continuation did not decrement remaining count");

	a_flag_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (bad_lead || end_of_string) |->
		seq_length == LEN_NONE && code_unit == 16'd0 && !(bad_lead && end_of_string))
		else $error("marker result carries payload");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pending result dropped");

endmodule

`default_nettype wire

### tb/utf8_decode_checker.sv
// utf8_decode_checker: watches both channels of the utf-8 to ucs-2 decoder,
// predicts each result from the accepted bytes and compares every transfer
// depends on u2u_pkg
module utf8_decode_checker
	import u2u_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [15:0] code_unit,
	input  wire logic [2:0]  seq_length,
	input  wire logic        end_of_string,
	input  wire logic        bad_lead,
	output int               mismatches,
	output int               outstanding
);

	dec_result_t     expected_units [$];
	dec_result_t     got;
	dec_result_t     want;
	logic [2:0]      left_bytes;
	logic [15:0]     gathered;
	logic [2:0]      lead_len;

	task automatic decode_byte(input logic [7:0] b);
		logic [2:0]  len;
		logic [15:0] payload;
		dec_result_t r;
		r = '0;
		if (left_bytes != 0) begin
			gathered = (gathered << 6) + {10'd0, b[5:0]};
			left_bytes = left_bytes - 3'd1;
			if (left_bytes == 0) begin
				r.code_unit = gathered;
				r.seq_length = lead_len;
				expected_units.push_back(r);
				gathered = '0;
				lead_len = LEN_NONE;
			end
		end else if (b == BYTE_NUL) begin
			r.end_of_string = 1'b1;
			expected_units.push_back(r);
		end else begin
			if (!b[7]) begin
				len = LEN_ONE;
				payload = {8'd0, b};
			end else if (!b[5]) begin
				len = LEN_TWO;
				payload = {11'd0, b[4:0]};
			end else if (!b[4]) begin
				len = LEN_THR;
				payload = {12'd0, b[3:0]};
			end else if (!b[3]) begin
				len = LEN_FOUR;
				payload = {13'd0, b[2:0]};
			end else if (!b[2]) begin
				len = LEN_FIVE;
				payload = {14'd0, b[1:0]};
			end else if (!b[1]) begin
				len = LEN_SIX;
				payload = {15'd0, b[0]};
			end else begin
				len = LEN_NONE;
				payload = '0;
			end
			if (len == LEN_NONE) begin
				r.bad_lead = 1'b1;
				expected_units.push_back(r);
			end else if (len == LEN_ONE) begin
				r.code_unit = payload;
				r.seq_length = LEN_ONE;
				expected_units.push_back(r);
			end else begin
				gathered = payload;
				lead_len = len;
				left_bytes = len - 3'd1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_units.delete();
			left_bytes = '0;
			gathered = '0;
			lead_len = LEN_NONE;
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{code_unit, seq_length, end_of_string, bad_lead};
				if (expected_units.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: code_unit %h seq_length %0d eos %b bad %b",
							got.code_unit, got.seq_length, got.end_of_string, got.bad_lead);
				end else begin
					want = expected_units.pop_front();
					if (got.code_unit !== want.code_unit
						|| got.seq_length !== want.seq_length
						|| got.end_of_string !== want.end_of_string
						|| got.bad_lead !== want.bad_lead) begin
						mismatches++;
						if (mismatches <= 10)
							$display("wrong result: code_unit %h/%h seq_length %0d/%0d eos %b/%b bad %b/%b",
								want.code_unit, got.code_unit, want.seq_length, got.seq_length,
								want.end_of_string, got.end_of_string, want.bad_lead, got.bad_lead);
					end
				end
			end
			if (in_valid && in_ready)
				decode_byte(in_byte);
			outstanding = expected_units.size();
		end
	end

endmodule

### tb/tb_utf8_to_ucs2_decoder.sv
// tb_utf8_to_ucs2_decoder: byte stimulus and verdict for the utf-8 to ucs-2 decoder
// depends on u2u_pkg, utf8_to_ucs2_decoder and utf8_decode_checker
module tb_utf8_to_ucs2_decoder;
	import u2u_pkg::*;

	localparam int CycleLimit = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] code_unit;
	logic [2:0]  seq_length;
	logic        end_of_string;
	logic        bad_lead;
	int          mismatches;
	int          outstanding;
	int          cycles = 0;
	int          bytes_sent = 0;
	int          stall_left = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	logic [7:0]  opening_bytes [$];

	always #5 clk = ~clk;

	utf8_to_ucs2_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_unit(code_unit),
		.seq_length(seq_length),
		.end_of_string(end_of_string),
		.bad_lead(bad_lead)
	);

	utf8_decode_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_unit(code_unit),
		.seq_length(seq_length),
		.end_of_string(end_of_string),
		.bad_lead(bad_lead),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("utf8_to_ucs2_decoder: mismatch");
			$finish;
		end
	end

	// receiver stalls in bursts while rx_idle_on is set, else it is always ready
	always @(negedge clk) begin
		if (!rx_idle_on) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic [7:0] make_lead(input logic [2:0] len);
		logic [7:0] r;
		r = 8'($urandom);
		case (len)
			LEN_ONE:  return 8'($urandom_range(1, 127));
			LEN_TWO:  return {1'b1, r[6], 1'b0, r[4:0]};
			LEN_THR:  return {1'b1, r[6], 2'b10, r[3:0]};
			LEN_FOUR: return {1'b1, r[6], 3'b110, r[2:0]};
			LEN_FIVE: return {1'b1, r[6], 4'b1110, r[1:0]};
			LEN_SIX:  return {1'b1, r[6], 5'b11110, r[0]};
			default:  return {1'b1, r[6], 5'b11111, r[0]};
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// mostly well-formed sequences with random content, the rest noise
	task automatic send_random_run();
		int          pick;
		logic [2:0]  len;
		logic [7:0]  cont;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			len = 3'($urandom_range(1, 6));
			send_byte(make_lead(len));
			for (int i = 1; i < len; i++) begin
				cont = 8'($urandom);
				if ($urandom_range(0, 9) != 0)
					cont[7:6] = 2'b10;
				send_byte(cont);
			end
		end else if (pick < 88) begin
			send_byte(BYTE_NUL);
		end else if (pick < 93) begin
			send_byte(make_lead(LEN_NONE));
		end else begin
			send_byte(8'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		// lengths one to six with extreme payloads, nul inside a sequence,
		// stray continuation as lead, and the unclassifiable leads
		opening_bytes = '{8'h00, 8'h7F, 8'h9F, 8'h80,
			8'hE2, 8'h00, 8'hAC,
			8'hF7, 8'hBF, 8'hBF, 8'hBF,
			8'hFB, 8'h80, 8'h80, 8'h80, 8'h80,
			8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
			8'hFE, 8'hFF, 8'hBE, 8'hBF};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (opening_bytes[i])
			send_byte(opening_bytes[i]);
		in_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
		while (bytes_sent < 550)
			send_random_run();
		tx_idle_on = 1'b0;
		while (bytes_sent < 850)
			send_random_run();
		in_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b0;
		while (bytes_sent < 1100)
			send_random_run();
		tx_idle_on = 1'b0;
		while (bytes_sent < 1400)
			send_random_run();
		in_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("utf8_to_ucs2_decoder: match");
		else
			$display("utf8_to_ucs2_decoder: mismatch");
		$finish;
	end

endmodule
